FILE: rtl/json_int64_array_formatter_assert.svh
// Assertion helpers used by the formatter datapath.
// Both macros sample on clk and are disabled while rst is high.
`ifndef JSON_INT64_ARRAY_FORMATTER_ASSERT_SVH
`define JSON_INT64_ARRAY_FORMATTER_ASSERT_SVH

// Same-cycle implication.
`define JIAF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define JIAF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/jiaf_pkg.sv
// ----------------------------------------------------------------------------
// jiaf_pkg
// Shared constants, types and helper functions of the JSON int64 array
// formatter.
// ----------------------------------------------------------------------------
package jiaf_pkg;

  localparam int COUNT_WIDTH     = 32;
  localparam int CAP_WIDTH       = 32;
  localparam int TOTAL_WIDTH     = 32;
  localparam int CMP_WIDTH       = ((COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH) + 2;
  localparam int NUM_WIDTH       = 64;
  localparam int NUM_DIGITS      = 20;
  localparam int BCD_WIDTH       = 4 * NUM_DIGITS;
  localparam int BITS_PER_STEP   = 4;
  localparam int CONV_STEPS      = NUM_WIDTH / BITS_PER_STEP;
  localparam int CONV_CNT_WIDTH  = $clog2(CONV_STEPS + 1);
  localparam int DIGIT_IDX_WIDTH = $clog2(NUM_DIGITS);
  localparam int DIGIT_CNT_WIDTH = $clog2(NUM_DIGITS + 1);
  localparam int APB_ADDR_WIDTH  = 3;
  localparam int APB_DATA_WIDTH  = 32;

  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [NUM_WIDTH-1:0] SMALL_LIMIT = NUM_WIDTH'(10000);
  localparam logic [CMP_WIDTH-1:0] SMALL_NEED  = CMP_WIDTH'(4);
  localparam logic [CAP_WIDTH-1:0] CAP_RESET   = CAP_WIDTH'(4096);
  localparam logic [CAP_WIDTH-1:0] CAP_MIN     = CAP_WIDTH'(2);

  typedef enum logic [0:0] {
    REG_OUTPUT_CAPACITY = 1'b0
  } reg_idx_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CAPACITY = 2'd1,
    STATUS_BAD_ARG  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    EK_OPEN,
    EK_COMMA,
    EK_MINUS,
    EK_DIGIT,
    EK_CLOSE,
    EK_STATUS
  } emit_kind_t;

  typedef struct packed {
    logic       idle;
    logic       emit;
    emit_kind_t kind;
    logic       done;
    logic       run_end;
    status_t    status;
    logic       w_set1;
    logic       w_inc;
    logic       w_save;
    logic       w_clear;
    logic       dig_start;
  } jiaf_cmd_t;

  typedef struct packed {
    logic item_valid;
    logic first;
    logic last;
    logic empty;
    logic neg;
    logic small_num;
    logic w_zero;
    logic cap_lt2;
    logic ovf_now;
    logic ovf_small;
    logic ovf_digits;
    logic conv_done;
    logic dig_last;
    logic emit_ok;
  } jiaf_stat_t;

  // One step of shift-and-add-3 binary to BCD conversion.
  function automatic logic [BCD_WIDTH-1:0] dd_shift(input logic [BCD_WIDTH-1:0] bcd,
                                                    input logic in_bit);
    logic [BCD_WIDTH-1:0] adj;
    adj = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_WIDTH-2:0], in_bit};
  endfunction

endpackage

FILE: rtl/jiaf_ifs.sv
// ----------------------------------------------------------------------------
// jiaf_item_if / jiaf_result_if
// Valid/ready channels for input requests and formatted result bytes.
// ----------------------------------------------------------------------------
interface jiaf_item_if import jiaf_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [NUM_WIDTH-1:0] number;
  logic                        first_of_array;
  logic                        last_of_array;
  logic                        empty_array;

  modport source (output valid, number, first_of_array, last_of_array, empty_array,
                  input ready);
  modport sink (input valid, number, first_of_array, last_of_array, empty_array,
                output ready);
endinterface

interface jiaf_result_if import jiaf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [7:0]             out_byte;
  logic                   byte_valid;
  logic                   run_end;
  logic                   array_done;
  logic [1:0]             status;
  logic [TOTAL_WIDTH-1:0] total_written;

  modport source (output valid, out_byte, byte_valid, run_end, array_done, status,
                  total_written, input ready);
  modport sink (input valid, out_byte, byte_valid, run_end, array_done, status,
                total_written, output ready);
endinterface

FILE: rtl/jiaf_regs.sv
// ----------------------------------------------------------------------------
// jiaf_regs
// APB configuration register holding the output capacity.
// ----------------------------------------------------------------------------
module jiaf_regs import jiaf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  output logic [CAP_WIDTH-1:0]      cap
);

  logic     sel_cap;
  reg_idx_t idx;

  assign idx     = reg_idx_t'(paddr[APB_ADDR_WIDTH-1]);
  assign sel_cap = (idx == REG_OUTPUT_CAPACITY);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (psel && penable && pwrite && sel_cap) begin
      cap <= pwdata[CAP_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (psel && sel_cap) begin
      prdata = APB_DATA_WIDTH'(cap);
    end
  end

endmodule

FILE: rtl/jiaf_datapath.sv
// ----------------------------------------------------------------------------
// jiaf_datapath
// Request registers, BCD converter, byte counter, bound checks and the
// result output register.
// ----------------------------------------------------------------------------
`include "json_int64_array_formatter_assert.svh"

module jiaf_datapath import jiaf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  jiaf_cmd_t            cmd,
  output jiaf_stat_t           stat,
  input  logic [CAP_WIDTH-1:0] cap,
  jiaf_item_if.sink            item,
  jiaf_result_if.source        result
);

  logic                       first_q;
  logic                       last_q;
  logic                       empty_q;
  logic                       neg_q;
  logic                       small_q;
  logic [NUM_WIDTH-1:0]       mag;
  logic [BCD_WIDTH-1:0]       bcd;
  logic [CONV_CNT_WIDTH-1:0]  conv_cnt;
  logic [CMP_WIDTH-1:0]       wcur;
  logic [CMP_WIDTH-1:0]       wcur_next;
  logic [COUNT_WIDTH-1:0]     wsaved;
  logic [DIGIT_IDX_WIDTH-1:0] dptr;
  logic [DIGIT_CNT_WIDTH-1:0] ndig;
  logic [BCD_WIDTH-1:0]       bcd_next;
  logic [NUM_WIDTH-1:0]       mag_next;
  logic [CMP_WIDTH-1:0]       cap_ext;
  logic [CMP_WIDTH-1:0]       wcur_plus1;
  logic [7:0]                 byte_sel;
  logic                       load;
  logic                       rvalid;

  assign item.ready = cmd.idle;
  assign load       = item.valid && item.ready;
  assign cap_ext    = CMP_WIDTH'(cap);
  assign wcur_plus1 = wcur + CMP_WIDTH'(1);

  // Several conversion steps per cycle, each a shift of one magnitude bit.
  always_comb begin
    bcd_next = bcd;
    mag_next = mag;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      bcd_next = dd_shift(bcd_next, mag_next[NUM_WIDTH-1]);
      mag_next = {mag_next[NUM_WIDTH-2:0], 1'b0};
    end
  end

  // Digit count: position of the highest nonzero digit, at least one.
  always_comb begin
    ndig = DIGIT_CNT_WIDTH'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        ndig = DIGIT_CNT_WIDTH'(i + 1);
      end
    end
  end

  always_comb begin
    wcur_next = wcur;
    if (cmd.w_set1) begin
      wcur_next = CMP_WIDTH'(1);
    end else if (cmd.w_inc) begin
      wcur_next = wcur_plus1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_cnt <= '0;
      wsaved   <= '0;
    end else begin
      if (load) begin
        conv_cnt <= CONV_CNT_WIDTH'(CONV_STEPS);
      end else if (conv_cnt != '0) begin
        conv_cnt <= conv_cnt - CONV_CNT_WIDTH'(1);
      end
      if (cmd.w_clear) begin
        wsaved <= '0;
      end else if (cmd.w_save) begin
        wsaved <= wcur_next[COUNT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      first_q <= item.first_of_array;
      last_q  <= item.last_of_array;
      empty_q <= item.empty_array;
      neg_q   <= item.number[NUM_WIDTH-1];
      small_q <= !item.number[NUM_WIDTH-1] && (item.number < $signed(SMALL_LIMIT));
      mag     <= item.number[NUM_WIDTH-1] ? (~item.number + NUM_WIDTH'(1)) : item.number;
      bcd     <= '0;
      wcur    <= CMP_WIDTH'(wsaved);
    end else begin
      if (conv_cnt != '0) begin
        bcd <= bcd_next;
        mag <= mag_next;
      end
      wcur <= wcur_next;
    end
    if (cmd.dig_start) begin
      dptr <= DIGIT_IDX_WIDTH'(ndig - DIGIT_CNT_WIDTH'(1));
    end else if (cmd.emit && cmd.kind == EK_DIGIT) begin
      dptr <= dptr - DIGIT_IDX_WIDTH'(1);
    end
  end

  always_comb begin
    unique case (cmd.kind)
      EK_OPEN:  byte_sel = CH_OPEN;
      EK_COMMA: byte_sel = CH_COMMA;
      EK_MINUS: byte_sel = CH_MINUS;
      EK_DIGIT: byte_sel = CH_ZERO | {4'd0, bcd[4*dptr +: 4]};
      EK_CLOSE: byte_sel = CH_CLOSE;
      default:  byte_sel = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else if (cmd.emit) begin
      rvalid <= 1'b1;
    end else if (result.ready) begin
      rvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.out_byte      <= byte_sel;
      result.byte_valid    <= (cmd.kind != EK_STATUS);
      result.run_end       <= cmd.run_end;
      result.array_done    <= cmd.done;
      result.status        <= cmd.status;
      result.total_written <= (cmd.kind == EK_CLOSE) ? wcur_plus1[TOTAL_WIDTH-1:0] : '0;
    end
  end

  assign result.valid = rvalid;

  always_comb begin
    stat.item_valid = item.valid;
    stat.first      = first_q;
    stat.last       = last_q;
    stat.empty      = empty_q;
    stat.neg        = neg_q;
    stat.small_num  = small_q;
    stat.w_zero     = (wsaved == '0);
    stat.cap_lt2    = (cap < CAP_MIN);
    stat.ovf_now    = (wcur >= cap_ext);
    stat.ovf_small  = ((wcur + SMALL_NEED) > cap_ext);
    stat.ovf_digits = ((wcur + CMP_WIDTH'(ndig)) > cap_ext);
    stat.conv_done  = (conv_cnt == '0);
    stat.dig_last   = (dptr == '0);
    stat.emit_ok    = !rvalid || result.ready;
  end

  `JIAF_ASSERT_SAME(a_digit_after_conv, cmd.emit && cmd.kind == EK_DIGIT, conv_cnt == '0, "digit emitted before conversion finished")
  `JIAF_ASSERT_SAME(a_emit_has_room, cmd.emit, !rvalid || result.ready, "result overwritten while stalled")
  `JIAF_ASSERT_SAME(a_status_result_shape, rvalid && !result.byte_valid, result.array_done && result.total_written == '0, "status result malformed")

endmodule

FILE: rtl/jiaf_ctrl.sv
// ----------------------------------------------------------------------------
// jiaf_ctrl
// Sequencer that walks one request through bracket, separator, sign,
// conversion, digits and close, with the capacity checks in between.
// ----------------------------------------------------------------------------
module jiaf_ctrl import jiaf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  jiaf_stat_t stat,
  output jiaf_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPEN,
    ST_SIGN,
    ST_CONV,
    ST_DIGIT,
    ST_CLOSE,
    ST_ABORT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.kind   = EK_STATUS;
    cmd.status = STATUS_OK;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        cmd.idle = 1'b1;
        if (stat.item_valid) begin
          state_next = ST_OPEN;
        end
      end
      ST_OPEN: begin
        if (!stat.first && !stat.empty && stat.w_zero) begin
          state_next = ST_IDLE;
        end else if (stat.first || stat.empty) begin
          if (stat.emit_ok) begin
            cmd.emit = 1'b1;
            if (stat.cap_lt2) begin
              cmd.kind    = EK_STATUS;
              cmd.status  = STATUS_BAD_ARG;
              cmd.done    = 1'b1;
              cmd.run_end = 1'b1;
              cmd.w_clear = 1'b1;
              state_next  = ST_IDLE;
            end else begin
              cmd.kind   = EK_OPEN;
              cmd.w_set1 = 1'b1;
              state_next = stat.empty ? ST_CLOSE : ST_SIGN;
            end
          end
        end else if (stat.ovf_now) begin
          state_next = ST_ABORT;
        end else if (stat.emit_ok) begin
          cmd.emit   = 1'b1;
          cmd.kind   = EK_COMMA;
          cmd.w_inc  = 1'b1;
          state_next = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (stat.small_num) begin
          state_next = stat.ovf_small ? ST_ABORT : ST_CONV;
        end else if (!stat.neg) begin
          state_next = ST_CONV;
        end else if (stat.ovf_now) begin
          state_next = ST_ABORT;
        end else if (stat.emit_ok) begin
          cmd.emit   = 1'b1;
          cmd.kind   = EK_MINUS;
          cmd.w_inc  = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (stat.conv_done) begin
          if (stat.ovf_digits) begin
            state_next = ST_ABORT;
          end else begin
            cmd.dig_start = 1'b1;
            state_next    = ST_DIGIT;
          end
        end
      end
      ST_DIGIT: begin
        if (stat.emit_ok) begin
          cmd.emit  = 1'b1;
          cmd.kind  = EK_DIGIT;
          cmd.w_inc = 1'b1;
          if (stat.dig_last) begin
            if (stat.last) begin
              state_next = ST_CLOSE;
            end else begin
              // The item leaves the array open; keep its byte count.
              cmd.run_end = 1'b1;
              cmd.w_save  = 1'b1;
              state_next  = ST_IDLE;
            end
          end
        end
      end
      ST_CLOSE: begin
        if (stat.ovf_now) begin
          state_next = ST_ABORT;
        end else if (stat.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.kind    = EK_CLOSE;
          cmd.done    = 1'b1;
          cmd.run_end = 1'b1;
          cmd.w_inc   = 1'b1;
          cmd.w_clear = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_ABORT: begin
        if (stat.emit_ok) begin
          cmd.emit    = 1'b1;
          cmd.kind    = EK_STATUS;
          cmd.status  = STATUS_CAPACITY;
          cmd.done    = 1'b1;
          cmd.run_end = 1'b1;
          cmd.w_clear = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/json_int64_array_formatter.sv
// Usage: requests arrive on the item channel (valid/ready), one signed 64-bit
// number per request with first, last and empty flags. Formatted JSON text
// leaves on the result channel one byte per result, with run_end on the
// last result of its request and array_done/status/total_written when
// an array ends. The APB port holds output_capacity (address 0).
// Timing: a request is taken only while the block is idle. The opening
// bracket or comma goes from the sequencer's open state into the output
// register; the decimal digits follow the binary to BCD converter, which
// handles four bits of the magnitude per cycle. Without stalls, the
// converter and the one-byte-per-cycle output set the throughput. A new
// request is taken only once the sequencer is back in idle after the last.
// Reset: the capacity returns to 4096 and no array is open; there is no
// clearing pass. When the receiver stalls, the current result is held in
// the output register and the sequencer waits.
// ----------------------------------------------------------------------------
// json_int64_array_formatter
// Top level: configuration register, sequencer and datapath.
// ----------------------------------------------------------------------------
module json_int64_array_formatter import jiaf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  jiaf_item_if.sink                 item,
  jiaf_result_if.source             result,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  logic [CAP_WIDTH-1:0] cap;
  jiaf_cmd_t            cmd;
  jiaf_stat_t           stat;

  jiaf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap     (cap)
  );

  jiaf_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  jiaf_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .stat   (stat),
    .cap    (cap),
    .item   (item),
    .result (result)
  );

endmodule

FILE: verif/json_int64_array_formatter_tb.sv
// ----------------------------------------------------------------------------
// json_int64_array_formatter_tb
// Feeds signed 64-bit numbers with array flags into the formatter and checks
// every result byte and status against a predictor of the JSON array text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_int64_array_formatter_tb;
  import jiaf_pkg::*;

  typedef struct packed {
    logic [63:0] number;
    logic        first;
    logic        last;
    logic        empty;
  } request_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_end;
    logic        array_done;
    logic [1:0]  status;
    logic [31:0] total_written;
  } text_t;

  typedef struct {
    request_t req;
    logic     has_ref;
    text_t    ref_res;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0] paddr = '0;
  logic [APB_DATA_WIDTH-1:0] pwdata = '0;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic pready;

  jiaf_item_if   item();
  jiaf_result_if result();

  json_int64_array_formatter dut (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state.
  logic [31:0] capacity;
  logic [31:0] open_bytes;
  text_t       pending_text[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          source_done = 1'b0;
  localparam int WATCHDOG = 20000;

  function automatic text_t mk(logic [7:0] b, logic v, logic d, status_t s,
                               logic [31:0] t);
    text_t r;
    r.out_byte = b; r.byte_valid = v; r.run_end = 1'b0; r.array_done = d;
    r.status = s; r.total_written = t;
    return r;
  endfunction

  // Appends the characters and status that one request produces.
  task automatic format_request(request_t rq);
    text_t       outq[$];
    logic [63:0] mag;
    logic [63:0] w;
    logic [7:0]  dig[$];
    bit          neg, ovf;
    ovf = 1'b0;
    mag = rq.number;
    neg = mag[63];
    w = open_bytes;
    if (!rq.first && !rq.empty && w == 0) return;
    if (rq.first || rq.empty) begin
      if (capacity < 2) begin
        outq.push_back(mk(8'h00, 1'b0, 1'b1, STATUS_BAD_ARG, 0));
        open_bytes = 0;
        outq[$].run_end = 1'b1;
        foreach (outq[i]) pending_text.push_back(outq[i]);
        return;
      end
      outq.push_back(mk(CH_OPEN, 1'b1, 1'b0, STATUS_OK, 0));
      w = 1;
      if (rq.empty) begin
        outq.push_back(mk(CH_CLOSE, 1'b1, 1'b1, STATUS_OK, 2));
        outq[$].run_end = 1'b1;
        open_bytes = 0;
        foreach (outq[i]) pending_text.push_back(outq[i]);
        return;
      end
    end else if (w >= capacity) begin
      ovf = 1'b1;
    end else begin
      outq.push_back(mk(CH_COMMA, 1'b1, 1'b0, STATUS_OK, 0));
      w++;
    end
    if (!ovf) begin
      if (!neg && mag < 64'd10000) begin
        if (w + 4 > capacity) ovf = 1'b1;
      end else if (neg) begin
        if (w >= capacity) ovf = 1'b1;
        else begin
          outq.push_back(mk(CH_MINUS, 1'b1, 1'b0, STATUS_OK, 0));
          w++;
          mag = ~mag + 64'd1;
        end
      end
    end
    if (!ovf) begin
      do begin
        dig.push_front(CH_ZERO + 8'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (w + dig.size() > capacity) ovf = 1'b1;
      else begin
        foreach (dig[i]) outq.push_back(mk(dig[i], 1'b1, 1'b0, STATUS_OK, 0));
        w += dig.size();
      end
    end
    if (!ovf && rq.last) begin
      if (w >= capacity) ovf = 1'b1;
      else begin
        w++;
        outq.push_back(mk(CH_CLOSE, 1'b1, 1'b1, STATUS_OK, w[31:0]));
        w = 0;
      end
    end
    if (ovf) begin
      outq.push_back(mk(8'h00, 1'b0, 1'b1, STATUS_CAPACITY, 0));
      w = 0;
    end
    outq[$].run_end = 1'b1;
    open_bytes = w[31:0];
    foreach (outq[i]) pending_text.push_back(outq[i]);
  endtask

  task automatic write_capacity(logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_ADDR_WIDTH'(REG_OUTPUT_CAPACITY) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    capacity = value;
  endtask

  task automatic drain();
    while (pending_text.size() != 0) @(posedge clk);
    // An ignored request may still be in flight.
    repeat (40) @(posedge clk);
  endtask

  task automatic gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  // Sends one request; the prediction is made at the accepting edge.
  // The block is never ready in the cycle after an acceptance, so the extra
  // wait before the next request costs no throughput.
  task automatic send(request_t rq);
    item.valid <= 1'b1;
    item.number <= rq.number;
    item.first_of_array <= rq.first;
    item.last_of_array <= rq.last;
    item.empty_array <= rq.empty;
    do @(posedge clk); while (!item.ready);
    format_request(rq);
    item.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_number();
    case ($urandom_range(0, 5))
      0: return 64'($urandom_range(0, 9999));
      1: return {$urandom, $urandom};
      2: return -64'($urandom_range(1, 99999));
      3: return 64'($urandom_range(10000, 999999));
      4: return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return $urandom_range(0, 1) ? 64'h8000_0000_0000_0000
                                           : 64'h7FFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  // Receiver: random stalls, checks against the oldest expectation.
  initial begin
    text_t want;
    result.ready = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (result.valid && result.ready) begin
        if (pending_text.size() == 0) begin
          $error("unexpected result byte %h", result.out_byte);
          errors++;
        end else begin
          want = pending_text.pop_front();
          if (result.out_byte !== want.out_byte) begin
            $error("out_byte exp %h got %h", want.out_byte, result.out_byte); errors++;
          end
          if (result.byte_valid !== want.byte_valid) begin
            $error("byte_valid exp %b got %b", want.byte_valid, result.byte_valid);
            errors++;
          end
          if (result.run_end !== want.run_end) begin
            $error("run_end exp %b got %b", want.run_end, result.run_end); errors++;
          end
          if (result.array_done !== want.array_done) begin
            $error("array_done exp %b got %b", want.array_done, result.array_done);
            errors++;
          end
          if (result.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, result.status); errors++;
          end
          if (result.total_written !== want.total_written) begin
            $error("total_written exp %0d got %0d", want.total_written,
                   result.total_written);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 19) == 0) result.ready <= 1'b0;
      else if ($urandom_range(0, 2) != 0) result.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (rst || (item.valid && item.ready) || (result.valid && result.ready) || source_done)
      idle_cycles <= 0;
    else if (item.valid || pending_text.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("json_int64_array_formatter_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    vector_t     plan[$];
    vector_t     v;
    request_t    rq;
    logic [31:0] caps[6];
    int          len;
    item.valid = 1'b0; item.number = '0;
    item.first_of_array = 1'b0; item.last_of_array = 1'b0; item.empty_array = 1'b0;
    capacity = 32'd4096;
    open_bytes = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: {number, first, last, empty}, optional typed result.
    plan.push_back('{'{64'd5, 1'b0, 1'b0, 1'b0}, 1'b0, '0});      // no open array
    plan.push_back('{'{64'd0, 1'b0, 1'b0, 1'b1}, 1'b0, '0});      // []
    plan.push_back('{'{64'd0, 1'b1, 1'b1, 1'b0}, 1'b0, '0});
    plan.push_back('{'{64'h8000_0000_0000_0000, 1'b1, 1'b0, 1'b0}, 1'b0, '0});
    plan.push_back('{'{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0}, 1'b0, '0});
    plan.push_back('{'{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0}, 1'b0, '0});
    plan.push_back('{'{64'd9999, 1'b0, 1'b0, 1'b0}, 1'b0, '0});
    plan.push_back('{'{64'd10000, 1'b0, 1'b1, 1'b0}, 1'b0, '0});
    plan.push_back('{'{64'd7, 1'b1, 1'b0, 1'b0}, 1'b0, '0});
    plan.push_back('{'{64'd8, 1'b1, 1'b0, 1'b0}, 1'b0, '0});      // restart mid-array
    plan.push_back('{'{64'd1, 1'b1, 1'b1, 1'b1}, 1'b0, '0});      // empty wins
    plan.push_back('{'{64'd3, 1'b0, 1'b1, 1'b0}, 1'b0, '0});      // ignored
    foreach (plan[i]) begin
      gap();
      send(plan[i].req);
    end
    drain();

    // Capacity below two gives a bad-argument status.
    write_capacity(32'd1);
    v = '{'{64'd1, 1'b1, 1'b0, 1'b0}, 1'b1, '0};
    v.ref_res = mk(8'h00, 1'b0, 1'b1, STATUS_BAD_ARG, 0);
    v.ref_res.run_end = 1'b1;
    send(v.req);
    if (pending_text.size() != 1 || pending_text[0] != v.ref_res) begin
      $error("bad-argument prediction exp %h got %h", v.ref_res, pending_text[0]);
      errors++;
    end
    send('{64'd0, 1'b0, 1'b0, 1'b1});
    drain();
    write_capacity(32'd0);
    send('{64'd2, 1'b1, 1'b1, 1'b0});
    drain();

    // Random phases across capacity settings, extremes among them.
    caps = '{32'd2, 32'd5, 32'd12, 32'd30, 32'hFFFF_FFFF, 32'd4096};
    foreach (caps[c]) begin
      write_capacity(caps[c]);
      for (int k = 0; k < 10; k++) begin
        len = $urandom_range(1, 6);
        for (int j = 0; j < len; j++) begin
          rq.number = rand_number();
          rq.first = (j == 0);
          rq.last = (j == len - 1);
          rq.empty = 1'b0;
          // Occasional noise and broken sequences.
          case ($urandom_range(0, 11))
            0: rq.empty = 1'b1;
            1: rq.first = $urandom_range(0, 1);
            2: rq.last = $urandom_range(0, 1);
            default: ;
          endcase
          gap();
          send(rq);
        end
      end
      drain();
    end

    source_done = 1'b1;
    if (errors == 0) $display("json_int64_array_formatter_tb: PASS");
    else $display("json_int64_array_formatter_tb: FAIL");
    $finish;
  end

endmodule
